[hdl/u128a_pkg.sv]
`timescale 1ns / 1ps
package u128a_pkg;
	typedef enum logic [4:0] {
		OP_AND = 5'd0, OP_OR = 5'd1, OP_XOR = 5'd2, OP_NOT = 5'd3, OP_SHL = 5'd4,
		OP_SHR = 5'd5, OP_EQ = 5'd6, OP_GT = 5'd7, OP_GE = 5'd8, OP_ZERO = 5'd9,
		OP_ADD = 5'd10, OP_SUB = 5'd11, OP_NEG = 5'd12, OP_DIV = 5'd13, OP_MOD = 5'd14,
		OP_GETBIT = 5'd15, OP_SETBIT = 5'd16
	} op_t;

	typedef struct packed {
		logic [4:0]  operation;
		logic [63:0] a_high;
		logic [63:0] a_low;
		logic [63:0] b_high;
		logic [63:0] b_low;
		logic [7:0]  amount;
		logic        bit_value;
	} alu_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic        divide_by_zero;
	} alu_out_t;
endpackage

[hdl/u128a_div_cell.sv]
`timescale 1ns / 1ps
module u128a_div_cell
	import u128a_pkg::*;
#(
	parameter int W = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vin,
	input  logic [W-1:0] num_in,
	input  logic [W-1:0] den_in,
	input  logic [W-1:0] rem_in,
	input  alu_in_t      item_in,
	output logic         vout,
	output logic [W-1:0] num_out,
	output logic [W-1:0] den_out,
	output logic [W-1:0] rem_out,
	output alu_in_t      item_out
);
	// One restoring step: shift the next dividend bit into the remainder,
	// subtract when it fits, and shift the quotient bit into the dividend.
	logic [W:0] sh;
	logic [W:0] diff;
	logic       fit;

	always_comb begin
		sh   = {rem_in, num_in[W-1]};
		diff = sh - {1'b0, den_in};
		fit  = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		rem_out  <= fit ? diff[W-1:0] : sh[W-1:0];
		num_out  <= {num_in[W-2:0], fit};
		den_out  <= den_in;
		item_out <= item_in;
	end
endmodule

[hdl/uint128_alu_with_divide.sv]
`timescale 1ns / 1ps
// Usage: drive item with start high; an item is taken at each clock edge with
// start high and busy low. Busy is always low, so one item may enter every cycle.
// Each item yields one result on result, marked by done for one cycle.
// Each item passes through a row of WORD_BITS division cells, one
// quotient bit per cell, followed by one output register. All operations
// travel the same row, so results leave in entry order.
// Operation codes 17 to 31 give a zero result. For DIV and MOD, a zero
// divisor gives a zero result with divide_by_zero set.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall: every result must be taken in its cycle.
module uint128_alu_with_divide
	import u128a_pkg::*;
#(
	parameter int WORD_BITS = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  alu_in_t  item,
	output logic     busy,
	output logic     done,
	output alu_out_t result
);
	localparam int W = WORD_BITS;
	localparam int AW = $clog2(W);

	logic [W-1:0] a, b;
	logic [W:0]   v;
	logic [W-1:0] num [W+1];
	logic [W-1:0] den [W+1];
	logic [W-1:0] rem [W+1];
	alu_in_t      it  [W+1];

	assign busy = 1'b0;
	assign a = W'({item.a_high, item.a_low});
	assign b = W'({item.b_high, item.b_low});

	assign v[0]   = start;
	assign num[0] = a;
	assign den[0] = b;
	assign rem[0] = '0;
	assign it[0]  = item;

	for (genvar i = 0; i < W; i++) begin : g_cell
		u128a_div_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vin(v[i]), .num_in(num[i]), .den_in(den[i]), .rem_in(rem[i]),
			.item_in(it[i]),
			.vout(v[i+1]), .num_out(num[i+1]), .den_out(den[i+1]),
			.rem_out(rem[i+1]), .item_out(it[i+1])
		);
	end

	alu_in_t      x;
	logic [W-1:0] xa, xb, r;
	logic         dz;
	logic [AW-1:0] amt;
	logic         amt_ok;

	always_comb begin
		x      = it[W];
		xa     = W'({x.a_high, x.a_low});
		xb     = W'({x.b_high, x.b_low});
		amt    = AW'(x.amount);
		amt_ok = {1'b0, x.amount} < 9'(W);
		r      = '0;
		dz     = 1'b0;
		case (x.operation)
			OP_AND:  r = xa & xb;
			OP_OR:   r = xa | xb;
			OP_XOR:  r = xa ^ xb;
			OP_NOT:  r = ~xa;
			OP_SHL:  r = amt_ok ? xa << amt : '0;
			OP_SHR:  r = amt_ok ? xa >> amt : '0;
			OP_EQ:   r = W'(xa == xb);
			OP_GT:   r = W'(xa > xb);
			OP_GE:   r = W'(xa >= xb);
			OP_ZERO: r = W'(xa == '0);
			OP_ADD:  r = xa + xb;
			OP_SUB:  r = xa - xb;
			OP_NEG:  r = '0 - xa;
			OP_DIV: begin
				dz = xb == '0;
				r  = dz ? '0 : num[W];
			end
			OP_MOD: begin
				dz = xb == '0;
				r  = dz ? '0 : rem[W];
			end
			OP_GETBIT: r = amt_ok ? W'(xa[amt]) : '0;
			OP_SETBIT: begin
				r = xa;
				if (amt_ok) begin
					r[amt] = x.bit_value;
				end
			end
			default: r = '0;
		endcase
	end

	logic [127:0] r128;
	assign r128 = 128'(r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v[W];
		end
	end

	always_ff @(posedge clk) begin
		result.result_high    <= r128[127:64];
		result.result_low     <= r128[63:0];
		result.divide_by_zero <= dz;
	end

	a_div_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> result.result_high == '0 && result.result_low == '0)
		else $error("divide by zero result not zero");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v[W] |=> done) else $error("result strobe lost");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule
